// ===== hdl/lcs_pkg.sv =====
// ----------------------------------------------------------------------------
// lcs_pkg: shared constants and helpers for the checkerboard square finder
// Holds frame dimension limits, field widths and register indexes.
// ----------------------------------------------------------------------------
package lcs_pkg;

  // Largest frame side the row buffer holds
  localparam int MAX_DIM = 256;
  // Width of every size, side and position field
  localparam int DIM_W   = 9;
  // Row buffer address width
  localparam int ADDR_W  = $clog2(MAX_DIM);
  // Row buffer word: cell bit on top of its side
  localparam int MEM_W   = DIM_W + 1;

  localparam logic [DIM_W-1:0] SIDE_MAX = {DIM_W{1'b1}};
  localparam logic [DIM_W-1:0] DIM_ONE  = DIM_W'(1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  // Frame size reset value
  localparam logic [DIM_W-1:0] SIZE_RESET = DIM_W'(MAX_DIM);

  typedef logic [DIM_W-1:0] dim_t;

  // Clamp a programmed size into 1..MAX_DIM
  function automatic dim_t eff_size(input dim_t v);
    dim_t res;
    if (v == '0) begin
      res = DIM_ONE;
    end else if (32'(v) > MAX_DIM) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// ===== hdl/lcs_ram.sv =====
// ----------------------------------------------------------------------------
// lcs_ram: generic single-port-write, single-port-read RAM
// Registered read with enable; a read of the entry being written returns
// the old contents.
// ----------------------------------------------------------------------------
module lcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/largest_checkerboard_square_top.sv =====
// Pipeline: an accepted input passes through the stage 1 register and the output register to out_*.
// Throughput: one cell per cycle while out_stall does not hold the output; set by the row buffer's
//   read-at-accept, write-at-retire cycle on one read and one write port.
// Reset: synchronous, active low; sets position to the first cell, clears neighbour and best state
//   and sets both frame sizes to 256. The row buffer is not cleared.
// ----------------------------------------------------------------------------
// largest_checkerboard_square_top: streaming checkerboard square finder
// Takes one matrix cell per transaction in row-major order and returns the
// side of the largest alternating square ending at that cell, plus the best
// square of the frame so far.
// ----------------------------------------------------------------------------
module largest_checkerboard_square_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_cell_bit,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lcs_pkg::DIM_W-1:0]         out_cell_side,
  output logic [lcs_pkg::DIM_W-1:0]         out_best_side,
  output logic [lcs_pkg::DIM_W-1:0]         out_best_row,
  output logic [lcs_pkg::DIM_W-1:0]         out_best_col,
  output logic                              out_frame_done,
  // configuration channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lcs_pkg::DIM_W-1:0]         cfg_data
);

  localparam int DW = lcs_pkg::DIM_W;
  localparam int AW = lcs_pkg::ADDR_W;
  localparam int MW = lcs_pkg::MEM_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [DW-1:0] width_r;
  logic [DW-1:0] height_r;
  logic          cfg_wr;

  // Registers are always writable; the port never pushes back.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= lcs_pkg::SIZE_RESET;
      height_r <= lcs_pkg::SIZE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        lcs_pkg::REG_FRAME_WIDTH:  width_r  <= cfg_data;
        lcs_pkg::REG_FRAME_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: stage 1 retires into the output register when that register
  // is empty or being drained; a new cell enters only as stage 1 frees up.
  // --------------------------------------------------------------------------
  logic s1_v_r;
  logic s1_adv;
  logic in_acc;
  logic out_valid_r;

  assign s1_adv   = s1_v_r & (~out_valid_r | ~out_stall);
  assign in_stall = s1_v_r & ~s1_adv;
  assign in_acc   = in_valid & ~in_stall;

  // --------------------------------------------------------------------------
  // Stage 0: cell position from the running counters
  // --------------------------------------------------------------------------
  logic [DW-1:0] col_r, row_r;
  logic [DW-1:0] col_nxt, row_nxt;
  logic [DW-1:0] w_eff, h_eff;
  logic [DW-1:0] pos_c, pos_r;
  logic [DW:0]   row_adj, col_inc, row_inc;
  logic [AW-1:0] rd_idx;

  always_comb begin
    w_eff = lcs_pkg::eff_size(width_r);
    h_eff = lcs_pkg::eff_size(height_r);

    // A column beyond the width starts the next row; a row beyond the
    // height starts a new frame.
    pos_c   = col_r;
    row_adj = {1'b0, row_r};
    if (col_r == '0 || col_r > w_eff) begin
      pos_c   = lcs_pkg::DIM_ONE;
      row_adj = {1'b0, row_r} + (DW+1)'(1);
    end
    if (row_adj == '0 || row_adj > {1'b0, h_eff}) begin
      pos_r = lcs_pkg::DIM_ONE;
    end else begin
      pos_r = row_adj[DW-1:0];
    end

    // Advance to the following cell
    col_inc = {1'b0, pos_c} + (DW+1)'(1);
    row_inc = {1'b0, pos_r} + (DW+1)'(1);
    if (col_inc > {1'b0, w_eff}) begin
      col_nxt = lcs_pkg::DIM_ONE;
      if (row_inc > {1'b0, h_eff}) begin
        row_nxt = lcs_pkg::DIM_ONE;
      end else begin
        row_nxt = row_inc[DW-1:0];
      end
    end else begin
      col_nxt = col_inc[DW-1:0];
      row_nxt = pos_r;
    end

    rd_idx = AW'(pos_c - lcs_pkg::DIM_ONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= lcs_pkg::DIM_ONE;
      row_r <= lcs_pkg::DIM_ONE;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 registers: the cell and its position, while the row buffer
  // read for the cell above completes
  // --------------------------------------------------------------------------
  logic          s1_bit_r;
  logic [DW-1:0] s1_c_r, s1_r_r;
  logic          s1_edge_r;
  logic          s1_first_r;
  logic          s1_done_r;
  logic [AW-1:0] s1_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_bit_r   <= in_cell_bit;
      s1_c_r     <= pos_c;
      s1_r_r     <= pos_r;
      s1_edge_r  <= (pos_c == lcs_pkg::DIM_ONE) | (pos_r == lcs_pkg::DIM_ONE);
      s1_first_r <= (pos_c == lcs_pkg::DIM_ONE) & (pos_r == lcs_pkg::DIM_ONE);
      s1_done_r  <= (pos_c == w_eff) & (pos_r == h_eff);
      s1_idx_r   <= rd_idx;
    end
  end

  // --------------------------------------------------------------------------
  // Row buffer: previous row's bits and sides. Read as the cell is accepted,
  // written back as it retires. The next cell reads a different column, so
  // no forwarding is needed; with a one-column frame the clash is harmless
  // because every cell sits on the first column.
  // --------------------------------------------------------------------------
  logic [MW-1:0] rd_data;
  logic [MW-1:0] wr_data;
  logic [DW-1:0] cell_side;

  assign wr_data = {s1_bit_r, cell_side};

  lcs_ram #(
    .WIDTH (MW),
    .DEPTH (lcs_pkg::MAX_DIM)
  ) u_row_buf (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_idx_r),
    .wdata (wr_data),
    .re    (in_acc),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  // --------------------------------------------------------------------------
  // Side computation and best tracking
  // --------------------------------------------------------------------------
  logic          left_bit_r, diag_bit_r;
  logic [DW-1:0] left_side_r, diag_side_r;
  logic [DW-1:0] best_len_r, best_row_r, best_col_r;

  logic          up_bit;
  logic [DW-1:0] up_side;
  logic [DW-1:0] min_lu, min3;
  logic [DW:0]   side_sum;
  logic [DW-1:0] base_len, base_row, base_col;
  logic [DW-1:0] best_len_nxt, best_row_nxt, best_col_nxt;

  always_comb begin
    up_bit  = rd_data[MW-1];
    up_side = rd_data[DW-1:0];

    min_lu   = (left_side_r < up_side) ? left_side_r : up_side;
    min3     = (min_lu < diag_side_r) ? min_lu : diag_side_r;
    side_sum = {1'b0, min3} + (DW+1)'(1);

    // Alternating pattern: differs from left and above, matches diagonal
    if (s1_edge_r) begin
      cell_side = lcs_pkg::DIM_ONE;
    end else if ((s1_bit_r != up_bit) && (s1_bit_r != left_bit_r) &&
                 (s1_bit_r == diag_bit_r)) begin
      cell_side = (side_sum > {1'b0, lcs_pkg::SIDE_MAX}) ? lcs_pkg::SIDE_MAX
                                                          : side_sum[DW-1:0];
    end else begin
      cell_side = lcs_pkg::DIM_ONE;
    end

    // Drop the previous frame's best at its first cell
    if (s1_first_r) begin
      base_len = '0;
      base_row = '0;
      base_col = '0;
    end else begin
      base_len = best_len_r;
      base_row = best_row_r;
      base_col = best_col_r;
    end

    // Strictly larger only: ties hold the earlier square
    if (cell_side > base_len) begin
      best_len_nxt = cell_side;
      best_row_nxt = s1_r_r;
      best_col_nxt = s1_c_r;
    end else begin
      best_len_nxt = base_len;
      best_row_nxt = base_row;
      best_col_nxt = base_col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_bit_r  <= 1'b0;
      left_side_r <= '0;
      diag_bit_r  <= 1'b0;
      diag_side_r <= '0;
      best_len_r  <= '0;
      best_row_r  <= '0;
      best_col_r  <= '0;
    end else if (s1_adv) begin
      left_bit_r  <= s1_bit_r;
      left_side_r <= cell_side;
      diag_bit_r  <= up_bit;
      diag_side_r <= up_side;
      best_len_r  <= best_len_nxt;
      best_row_r  <= best_row_nxt;
      best_col_r  <= best_col_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [DW-1:0] out_cell_side_r, out_best_side_r, out_best_row_r, out_best_col_r;
  logic          out_frame_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (~out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_cell_side_r  <= cell_side;
      out_best_side_r  <= best_len_nxt;
      out_best_row_r   <= best_row_nxt;
      out_best_col_r   <= best_col_nxt;
      out_frame_done_r <= s1_done_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_side  = out_cell_side_r;
  assign out_best_side  = out_best_side_r;
  assign out_best_row   = out_best_row_r;
  assign out_best_col   = out_best_col_r;
  assign out_frame_done = out_frame_done_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A stalled stage 1 must keep its row buffer read data
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_adv) |=> $stable(rd_data))
    else $error("row buffer read data changed under a stalled stage 1");

  // Every result carries a side of at least one
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cell_side != '0))
    else $error("result with zero cell side");

  // The best square can never be smaller than the current cell's square
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_best_side >= out_cell_side))
    else $error("best side below cell side");

  // Position counters never rest at zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (col_r != '0) && (row_r != '0))
    else $error("position counter at zero");

endmodule
